### design/sirdg_pkg.sv
package sirdg_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int MAX_RADIX_DEF = 16;

    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 8;
    localparam int RADIX_W    = 5;
    localparam int CFG_W      = 64;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_IDX_W  = 2;
    localparam int NUM_DIGITS = 16;

    localparam logic [CHAR_W-1:0]  MINUS_CHAR = 8'h2D;
    localparam logic [RADIX_W-1:0] MIN_RADIX  = 5'd2;

    localparam logic [REG_IDX_W-1:0] REG_RADIX      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CHARS_LOW  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CHARS_HIGH = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_RESET      = 5'd8;
    localparam logic [CFG_W-1:0]   CHARS_LOW_RESET  = 64'h3736_3534_3332_3130;
    localparam logic [CFG_W-1:0]   CHARS_HIGH_RESET = 64'h0;

    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic [CFG_W-1:0]   chars_low;
        logic [CFG_W-1:0]   chars_high;
    } cfg_t;

    typedef struct packed {
        logic               done;
        logic [DIGIT_W-1:0] remainder;
    } div_rsp_t;

    function automatic logic [CHAR_W-1:0] char_lookup(
        input logic [CFG_W-1:0]   chars_low,
        input logic [CFG_W-1:0]   chars_high,
        input logic [DIGIT_W-1:0] digit
    );
        logic [NUM_DIGITS*CHAR_W-1:0] alphabet;
        alphabet = {chars_high, chars_low};
        return alphabet[digit*CHAR_W +: CHAR_W];
    endfunction

endpackage

### design/sirdg_cfg_regs.sv
module sirdg_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sirdg_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [sirdg_pkg::CFG_W-1:0]       pwdata,
    output logic [sirdg_pkg::CFG_W-1:0]       prdata,
    output logic                              pready,
    output sirdg_pkg::cfg_t                   cfg
);
    import sirdg_pkg::*;

    logic [RADIX_W-1:0]   radix_reg;
    logic [CFG_W-1:0]     chars_low_reg;
    logic [CFG_W-1:0]     chars_high_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg      <= RADIX_RESET;
            chars_low_reg  <= CHARS_LOW_RESET;
            chars_high_reg <= CHARS_HIGH_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_RADIX:      radix_reg      <= pwdata[RADIX_W-1:0];
                REG_CHARS_LOW:  chars_low_reg  <= pwdata;
                REG_CHARS_HIGH: chars_high_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RADIX:      prdata = CFG_W'(radix_reg);
            REG_CHARS_LOW:  prdata = chars_low_reg;
            REG_CHARS_HIGH: prdata = chars_high_reg;
            default:        prdata = '0;
        endcase
    end

    assign cfg.radix      = radix_reg;
    assign cfg.chars_low  = chars_low_reg;
    assign cfg.chars_high = chars_high_reg;

endmodule

### design/sirdg_div_unit.sv
module sirdg_div_unit #(
    parameter int WORD_BITS = sirdg_pkg::WORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [WORD_BITS-1:0]          dividend,
    input  logic [sirdg_pkg::RADIX_W-1:0] divisor,
    output logic [WORD_BITS-1:0]          quotient,
    output sirdg_pkg::div_rsp_t           rsp
);
    import sirdg_pkg::*;

    // restoring division, one quotient digit of DIGIT_W bits per cycle
    localparam int STEPS      = (WORD_BITS + DIGIT_W - 1) / DIGIT_W;
    localparam int PAD_W      = STEPS * DIGIT_W;
    localparam int STEP_CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [PAD_W-1:0]      q_reg;
    logic [DIGIT_W-1:0]    rem_reg;
    logic [STEP_CNT_W-1:0] step_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [RADIX_W-1:0]    part;
    logic [DIGIT_W-1:0]    qbits;
    logic [DIGIT_W-1:0]    rem_step;

    always_comb begin
        part  = {1'b0, rem_reg};
        qbits = '0;
        for (int i = 0; i < DIGIT_W; i++) begin
            part = {part[RADIX_W-2:0], q_reg[PAD_W-1-i]};
            if (part >= divisor) begin
                part = part - divisor;
                qbits[DIGIT_W-1-i] = 1'b1;
            end
        end
        rem_step = part[DIGIT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_CNT_W'(STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= PAD_W'(dividend);
            rem_reg <= '0;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[PAD_W-DIGIT_W-1:0], qbits};
            rem_reg <= rem_step;
        end
    end

    assign quotient      = q_reg[WORD_BITS-1:0];
    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

### design/signed_int_to_radix_digits_unit.sv
// Signed integer to text in a programmable radix (2..16).
// s_axis carries one two's-complement word per transfer; m_axis returns its
// characters one word at a time, most significant first, with a leading '-'
// for negative values and m_axis_tlast on the final character.
// Registers over APB: radix at 0x00, digit chars 0..7 at 0x08, 8..15 at 0x10.
// A radix above 16 acts as 16, below 2 acts as 2.
// Each digit takes one pass of the shared divider (4 quotient bits per cycle);
// the characters then go out one per cycle while m_axis_tready is high.
// s_axis_tready is high only while idle, which includes while the last
// character still sits in the output register.
// A stalled receiver holds the output register and the block waits.
// Reset (aresetn low, synchronous) returns to idle, drops m_axis_tvalid and
// restores radix 8 and alphabet "01234567".
module signed_int_to_radix_digits_unit #(
    parameter int WORD_BITS = sirdg_pkg::WORD_BITS_DEF,
    parameter int MAX_RADIX = sirdg_pkg::MAX_RADIX_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((WORD_BITS + 7) / 8) * 8-1:0]  s_axis_tdata,  // value
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [sirdg_pkg::CHAR_W-1:0]          m_axis_tdata,  // char_out
    output logic                                  m_axis_tlast,  // last_char
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [sirdg_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [sirdg_pkg::CFG_W-1:0]           pwdata,
    output logic [sirdg_pkg::CFG_W-1:0]           prdata,
    output logic                                  pready
);
    import sirdg_pkg::*;

    localparam int STACK_W = WORD_BITS * DIGIT_W;
    localparam int CNT_W   = $clog2(WORD_BITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                neg_reg, neg_next;
    logic [STACK_W-1:0]  stack_reg, stack_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [CHAR_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                m_tlast_reg, m_tlast_next;

    cfg_t                cfg;
    div_rsp_t            div_rsp;
    logic [WORD_BITS-1:0] div_quotient;
    logic [WORD_BITS-1:0] div_dividend;
    logic                div_start;
    logic [RADIX_W-1:0]  radix_eff;

    logic                accept;
    logic [WORD_BITS-1:0] in_value;
    logic                in_neg;
    logic [WORD_BITS-1:0] in_mag;
    logic [CNT_W-1:0]    count_inc;
    logic                more_digits;
    logic                out_free;

    sirdg_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sirdg_div_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (radix_eff),
        .quotient (div_quotient),
        .rsp      (div_rsp)
    );

    always_comb begin
        if (cfg.radix > RADIX_W'(MAX_RADIX)) begin
            radix_eff = RADIX_W'(MAX_RADIX);
        end else if (cfg.radix < MIN_RADIX) begin
            radix_eff = MIN_RADIX;
        end else begin
            radix_eff = cfg.radix;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_value      = s_axis_tdata[WORD_BITS-1:0];
    assign in_neg        = in_value[WORD_BITS-1];
    assign in_mag        = in_neg ? (~in_value + 1'b1) : in_value;

    assign count_inc   = count_reg + 1'b1;
    assign more_digits = (div_quotient != '0) && (count_inc < CNT_W'(WORD_BITS));
    assign div_start   = accept || ((state_reg == ST_DIVIDE) && div_rsp.done && more_digits);
    assign div_dividend = accept ? in_mag : div_quotient;
    assign out_free    = !m_tvalid_reg || m_axis_tready;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        neg_next      = neg_reg;
        stack_next    = stack_reg;
        m_tvalid_next = m_tvalid_reg && !m_axis_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    neg_next   = in_neg;
                    count_next = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_rsp.done) begin
                    stack_next = {stack_reg[STACK_W-DIGIT_W-1:0], div_rsp.remainder};
                    count_next = count_inc;
                    if (!more_digits) begin
                        state_next = neg_reg ? ST_SIGN : ST_EMIT;
                    end
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = MINUS_CHAR;
                    m_tlast_next  = 1'b0;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = char_lookup(cfg.chars_low, cfg.chars_high,
                                                stack_reg[DIGIT_W-1:0]);
                    m_tlast_next  = (count_reg == CNT_W'(1));
                    stack_next    = stack_reg >> DIGIT_W;
                    count_next    = count_reg - 1'b1;
                    if (count_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        stack_reg   <= stack_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            neg_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            neg_reg      <= neg_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tlast  = m_tlast_reg;

    a_idle_no_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (count_reg == '0))
        else $error("digits left over while idle");

    a_done_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside divide phase");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(WORD_BITS))
        else $error("digit count overflow");

    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SIGN) && out_free) |=> (m_axis_tvalid && !m_axis_tlast))
        else $error("minus sign flagged last");

endmodule

### bench/radix_text_checker.sv
module radix_text_checker #(
    parameter int WORD_W = sirdg_pkg::WORD_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [WORD_W-1:0]                s_axis_tdata,   // value
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [sirdg_pkg::CHAR_W-1:0]     m_axis_tdata,   // char_out
    input  logic                             m_axis_tlast,   // last_char
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sirdg_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sirdg_pkg::CFG_W-1:0]      pwdata,
    input  logic [sirdg_pkg::CFG_W-1:0]      prdata,
    input  logic                             pready,
    output int                               errors,
    output int                               pending
);
    import sirdg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CHAR_W-1:0] glyph;
        logic              last;
    } text_word_t;

    text_word_t         expected_chars[$];
    logic [RADIX_W-1:0] radix_q;
    logic [CFG_W-1:0]   low_q;
    logic [CFG_W-1:0]   high_q;

    initial begin
        errors  = 0;
        pending = 0;
    end

    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
        if (d[DIGIT_W-1])
            return high_q[d[DIGIT_W-2:0]*CHAR_W +: CHAR_W];
        return low_q[d[DIGIT_W-2:0]*CHAR_W +: CHAR_W];
    endfunction

    // digits come out least significant first, text goes out most significant first
    function automatic void predict_text(input logic [WORD_W-1:0] value);
        logic [WORD_W-1:0]  mag;
        logic [WORD_W-1:0]  base;
        logic [DIGIT_W-1:0] digits [WORD_W];
        int                 n;
        int                 k;
        base = WORD_W'(radix_q);
        if (base > MAX_RADIX_DEF)
            base = WORD_W'(MAX_RADIX_DEF);
        if (base < MIN_RADIX)
            base = WORD_W'(MIN_RADIX);
        mag = value[WORD_W-1] ? -value : value;
        n = 0;
        do begin
            digits[n] = DIGIT_W'(mag % base);
            mag = mag / base;
            n++;
        end while (mag != 0 && n < WORD_W);
        if (value[WORD_W-1])
            expected_chars.push_back('{MINUS_CHAR, 1'b0});
        for (k = n - 1; k >= 0; k--)
            expected_chars.push_back('{digit_glyph(digits[k]), k == 0});
    endfunction

    always @(posedge aclk) begin
        text_word_t           want;
        logic [REG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     want_rd;
        logic                 known;
        if (!aresetn) begin
            radix_q = RADIX_RESET;
            low_q   = CHARS_LOW_RESET;
            high_q  = CHARS_HIGH_RESET;
            expected_chars.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected word: char_out %h last_char %b",
                           m_axis_tdata, m_axis_tlast);
                    errors++;
                end else begin
                    want = expected_chars.pop_front();
                    if (m_axis_tdata !== want.glyph) begin
                        $error("char_out expected %h got %h", want.glyph, m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last_char expected %b got %b", want.last, m_axis_tlast);
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_text(s_axis_tdata);
            if (psel && penable && pready) begin
                reg_idx = paddr[CFG_ADDR_W-1:3];
                known   = 1'b1;
                want_rd = '0;
                case (reg_idx)
                    REG_RADIX: begin
                        if (pwrite)
                            radix_q = pwdata[RADIX_W-1:0];
                        want_rd = CFG_W'(radix_q);
                    end
                    REG_CHARS_LOW: begin
                        if (pwrite)
                            low_q = pwdata;
                        want_rd = low_q;
                    end
                    REG_CHARS_HIGH: begin
                        if (pwrite)
                            high_q = pwdata;
                        want_rd = high_q;
                    end
                    default: known = 1'b0;
                endcase
                if (!pwrite && known && prdata !== want_rd) begin
                    $error("prdata expected %h got %h", want_rd, prdata);
                    errors++;
                end
            end
        end
        pending = expected_chars.size();
    end

endmodule

### bench/tb.sv
module tb;
    import sirdg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 270;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 40;

    localparam logic [REG_IDX_W-1:0]  REG_SPARE   = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] ADDR_RADIX  = {REG_RADIX, 3'b000};
    localparam logic [CFG_ADDR_W-1:0] ADDR_LOW    = {REG_CHARS_LOW, 3'b000};
    localparam logic [CFG_ADDR_W-1:0] ADDR_HIGH   = {REG_CHARS_HIGH, 3'b000};
    localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE  = {REG_SPARE, 3'b000};

    localparam logic [CFG_W-1:0] HEX_LOW  = 64'h3736_3534_3332_3130;
    localparam logic [CFG_W-1:0] HEX_HIGH = 64'h4645_4443_4241_3938;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata;   // value
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [CHAR_W-1:0]     m_axis_tdata;   // char_out
    logic                  m_axis_tlast;   // last_char
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_W-1:0]      pwdata;
    logic [CFG_W-1:0]      prdata;
    logic                  pready;
    int                    errors;
    int                    pending;
    int                    burst_left  = 0;
    int                    idle_cycles = 0;
    logic [15:0]           ready_pattern = 16'hFFFF;
    int                    pattern_left  = 0;

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    signed_int_to_radix_digits_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    radix_text_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .errors        (errors),
        .pending       (pending)
    );

    // receiver backpressure, a rotating ready pattern that is redrawn at random intervals
    always @(negedge aclk) begin
        if (pattern_left == 0) begin
            case ($urandom_range(0, 3))
                0:       ready_pattern = 16'hFFFF;
                1:       ready_pattern = 16'($urandom);
                2:       ready_pattern = 16'($urandom | $urandom);
                default: ready_pattern = 16'($urandom & $urandom);
            endcase
            pattern_left = $urandom_range(16, 200);
        end
        pattern_left--;
        m_axis_tready = ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic apb_access(input logic is_write, input logic [CFG_ADDR_W-1:0] addr,
                              input logic [CFG_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = is_write;
        paddr   = addr;
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic read_all();
        apb_access(1'b0, ADDR_RADIX, '0);
        apb_access(1'b0, ADDR_LOW, '0);
        apb_access(1'b0, ADDR_HIGH, '0);
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_format(input logic [RADIX_W-1:0] r, input logic [CFG_W-1:0] lo,
                              input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] radix_word;
        drain();
        radix_word = {$urandom, $urandom};
        radix_word[RADIX_W-1:0] = r;
        apb_access(1'b1, ADDR_RADIX, radix_word);
        apb_access(1'b1, ADDR_LOW, lo);
        apb_access(1'b1, ADDR_HIGH, hi);
        read_all();
    endtask

    task automatic send_value(input logic [31:0] v);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = v;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = $urandom_range(0, 40);
            1:       v = -$urandom_range(1, 40);
            2:       v = 32'h8000_0000 + $urandom_range(0, 3);
            3:       v = 32'h7FFF_FFFF - $urandom_range(0, 3);
            4:       v = $urandom >> $urandom_range(0, 31);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic random_format();
        logic [RADIX_W-1:0] r;
        logic [CFG_W-1:0]   lo;
        logic [CFG_W-1:0]   hi;
        r = ($urandom_range(0, 3) == 0) ? RADIX_W'($urandom_range(0, 31)) :
                                          RADIX_W'($urandom_range(2, 16));
        case ($urandom_range(0, 2))
            0: begin
                lo = HEX_LOW;
                hi = HEX_HIGH;
            end
            1: begin
                lo = {$urandom, $urandom};
                hi = {$urandom, $urandom};
            end
            default: begin
                lo = {$urandom, $urandom} & {$urandom, $urandom};
                hi = {$urandom, $urandom} | {$urandom, $urandom};
            end
        endcase
        set_format(r, lo, hi);
    endtask

    initial begin
        int sent;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset format: octal, "01234567"
        read_all();
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'd7);
        send_value(32'd8);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);

        // write past the register list must be dropped
        drain();
        apb_access(1'b1, ADDR_SPARE, {$urandom, $urandom});
        read_all();

        // binary, all-zero and all-one alphabets; most negative gives the longest text
        set_format(5'd2, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'd0);
        send_value(32'hFFFF_FFFF);

        set_format(5'd16, HEX_LOW, HEX_HIGH);
        send_value(32'hFFFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'hDEAD_BEEF);
        send_value(32'd15);

        // radix above 16 clamps
        set_format(5'd31, HEX_LOW, HEX_HIGH);
        send_value(32'h1234_5678);
        send_value(32'hFFFF_FFF0);

        // radix 0 and 1 act as binary
        set_format(5'd0, HEX_LOW, HEX_HIGH);
        send_value(32'd5);
        send_value(32'hFFFF_FFFB);
        set_format(5'd1, HEX_LOW, HEX_HIGH);
        send_value(32'd6);

        // decimal with zero, repeated, '+' and '-' glyphs
        set_format(5'd10, 64'h2D2B_2D00_3131_3030, 64'hFFFF_FFFF_FFFF_3938);
        send_value(32'd1_000_000_000);
        send_value(32'h8000_0000);
        send_value(32'd9);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            random_format();
            repeat ($urandom_range(10, 40)) begin
                send_value(random_value());
                sent++;
            end
        end

        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
